[src/onb_pkg.sv]
// shared types, widths and saturating arithmetic for the octree node builder
package onb_pkg;

    localparam int KEY_W   = 63;
    localparam int SUM_W   = 64;
    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int TMASS_W = 64;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = 31;
    localparam int LVL_W   = 5;
    localparam int LIM_W   = 8;
    localparam logic [LIM_W-1:0] LIMIT_RST = 8'd8;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [SUM_W-1:0] px;
        logic signed [SUM_W-1:0] py;
        logic signed [SUM_W-1:0] pz;
        logic [MASS_W-1:0]       mass;
        logic [IDX_W-1:0]        idx;
    } t_part;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [LVL_W-1:0]        level;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic [TMASS_W-1:0]      mass;
        logic [CNT_W-1:0]        count;
        logic [IDX_W-1:0]        start;
    } t_node;

    // flush: a level above missed; quiet/dquiet: emission already stopped
    typedef struct packed {
        logic flush;
        logic quiet;
        logic dquiet;
    } t_link;

    typedef struct packed {
        logic  flag;
        logic  tree_end;
        t_node node;
    } t_entry;

    function automatic logic signed [SUM_W-1:0] sat_add_s(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
            s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s;
    endfunction

    function automatic logic [TMASS_W-1:0] sat_add_m(
        input logic [TMASS_W-1:0] a,
        input logic [MASS_W-1:0]  b
    );
        logic [TMASS_W:0] s;
        s = {1'b0, a} + {{(TMASS_W-MASS_W+1){1'b0}}, b};
        return s[TMASS_W] ? {TMASS_W{1'b1}} : s[TMASS_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (&a) ? a : a + CNT_W'(1);
    endfunction

endpackage

[src/onb_node_cell.sv]
// one tree level: open node storage, prefix match, accumulate or replace
module onb_node_cell import onb_pkg::*; #(
    parameter int LEVELS = 21,
    parameter int LVL    = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_seeded,
    input  logic             i_last,
    input  logic [LIM_W-1:0] i_limit,
    input  t_part            i_part,
    input  t_link            i_link,
    output t_link            o_link,
    output t_node            o_old,
    output logic             o_old_flag,
    output t_node            o_new,
    output logic             o_dump_flag
);
    localparam int SHIFT = 3 * (LEVELS - 1 - LVL);

    t_node             r_node;
    t_node             n_node;
    logic [KEY_W-1:0]  pfx;
    logic              flush_here;
    logic [CNT_W-1:0]  limit_ext;

    assign pfx        = i_part.key >> SHIFT;
    assign flush_here = i_link.flush | (pfx != r_node.key);
    assign limit_ext  = {{(CNT_W-LIM_W){1'b0}}, i_limit};

    always_comb begin
        n_node       = r_node;
        n_node.level = LVL_W'(LVL + 1);
        if (!i_seeded || flush_here) begin
            n_node.key   = pfx;
            n_node.sx    = i_part.px;
            n_node.sy    = i_part.py;
            n_node.sz    = i_part.pz;
            n_node.mass  = {{(TMASS_W-MASS_W){1'b0}}, i_part.mass};
            n_node.count = CNT_W'(1);
            n_node.start = i_seeded ? i_part.idx : '0;
        end else begin
            n_node.sx    = sat_add_s(r_node.sx, i_part.px);
            n_node.sy    = sat_add_s(r_node.sy, i_part.py);
            n_node.sz    = sat_add_s(r_node.sz, i_part.pz);
            n_node.mass  = sat_add_m(r_node.mass, i_part.mass);
            n_node.count = sat_inc(r_node.count);
        end
    end

    assign o_old_flag   = i_seeded & flush_here & ~i_link.quiet;
    assign o_link.flush = flush_here;
    assign o_link.quiet = i_link.quiet | (flush_here & (r_node.count <= limit_ext));
    assign o_dump_flag  = i_last & ~i_link.dquiet;
    assign o_link.dquiet = i_link.dquiet | (n_node.count <= limit_ext);
    assign o_old        = r_node;
    assign o_new        = n_node;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_node <= n_node;
        end
    end

endmodule

[src/onb_emit_cell.sv]
// one slot of the emit shift chain, loads a snapshot or takes its neighbor
module onb_emit_cell import onb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  logic   i_shift,
    input  t_entry i_load_entry,
    input  t_entry i_next,
    output t_entry o_entry
);
    logic  r_flag;
    logic  r_end;
    t_node r_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_load) begin
            r_flag <= i_load_entry.flag;
        end else if (i_shift) begin
            r_flag <= i_next.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_end  <= i_load_entry.tree_end;
            r_node <= i_load_entry.node;
        end else if (i_shift) begin
            r_end  <= i_next.tree_end;
            r_node <= i_next.node;
        end
    end

    assign o_entry.flag     = r_flag;
    assign o_entry.tree_end = r_end;
    assign o_entry.node     = r_node;

endmodule

[src/octree_node_builder.sv]
// top level: octree node builder over key-sorted particles
// Input channel: i_in_valid / o_in_stall, one particle per request.
// Output channel: o_out_valid / i_out_stall, one tree node per request.
// Config channel: i_cfg_valid / o_cfg_ready writes leaf_limit (always ready).
// A particle spends two register stages (capture, mass*position multiply)
// before it reaches the row of level cells, which update all open nodes
// together. Particles that close no node flow at one per cycle while the chain is empty.
// When a particle closes nodes, the old nodes (and on the last particle the
// dumped stack) are loaded into a shift chain of 2*LEVELS slots that moves
// one slot per cycle toward the output register unless a stalled output
// holds it; the input stalls until the chain has drained.
// Reset clears the pipeline, the chain and the output, forgets the open tree
// and sets leaf_limit to 8. A stalled output holds its node and the chain
// waits behind it.
module octree_node_builder import onb_pkg::*; #(
    parameter int LEVELS = 21
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [KEY_W-1:0]         i_key,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [MASS_W-1:0]        i_mass,
    input  logic [IDX_W-1:0]         i_particle_index,
    input  logic                     i_last_particle,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LIM_W-1:0]         i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [KEY_W-1:0]         o_node_prefix,
    output logic [LVL_W-1:0]         o_node_level,
    output logic signed [SUM_W-1:0]  o_sum_x,
    output logic signed [SUM_W-1:0]  o_sum_y,
    output logic signed [SUM_W-1:0]  o_sum_z,
    output logic [TMASS_W-1:0]       o_total_mass,
    output logic [CNT_W-1:0]         o_node_count,
    output logic [IDX_W-1:0]         o_start_index,
    output logic                     o_tree_end,
    output logic                     o_last_of_run
);
    localparam int SLOTS = 2 * LEVELS;

    logic [LIM_W-1:0] r_limit;
    logic             r_seeded;

    // capture stage
    logic                    r_a_valid;
    logic [KEY_W-1:0]        r_a_key;
    logic signed [POS_W-1:0] r_a_x, r_a_y, r_a_z;
    logic [MASS_W-1:0]       r_a_mass;
    logic [IDX_W-1:0]        r_a_idx;
    logic                    r_a_last;

    // product stage
    logic  r_b_valid;
    t_part r_b_part;
    logic  r_b_last;

    logic a_free, b_free, b_go, chain_empty;
    logic signed [SUM_W:0] prod_x, prod_y, prod_z;

    t_link links [LEVELS+1];
    t_node old_n [LEVELS];
    t_node new_n [LEVELS];
    logic [LEVELS-1:0] old_flag, dump_flag;

    t_entry ent [SLOTS+1];
    t_entry load_ent [SLOTS];
    logic [SLOTS-1:0] ent_flag;
    logic out_take, shift;

    logic  r_o_valid;
    t_node r_o_node;
    logic  r_o_end, r_o_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    assign chain_empty = ~|ent_flag;
    assign b_go        = r_b_valid & chain_empty;
    assign b_free      = ~r_b_valid | b_go;
    assign a_free      = ~r_a_valid | b_free;
    assign o_in_stall  = ~a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_seeded  <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (b_go) begin
                r_seeded <= ~r_b_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_in_valid) begin
            r_a_key  <= i_key;
            r_a_x    <= i_pos_x;
            r_a_y    <= i_pos_y;
            r_a_z    <= i_pos_z;
            r_a_mass <= i_mass;
            r_a_idx  <= i_particle_index;
            r_a_last <= i_last_particle;
        end
    end

    assign prod_x = r_a_x * $signed({1'b0, r_a_mass});
    assign prod_y = r_a_y * $signed({1'b0, r_a_mass});
    assign prod_z = r_a_z * $signed({1'b0, r_a_mass});

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_valid) begin
            r_b_part.key  <= r_a_key;
            r_b_part.px   <= prod_x[SUM_W-1:0];
            r_b_part.py   <= prod_y[SUM_W-1:0];
            r_b_part.pz   <= prod_z[SUM_W-1:0];
            r_b_part.mass <= r_a_mass;
            r_b_part.idx  <= r_a_idx;
            r_b_last      <= r_a_last;
        end
    end

    assign links[0] = '0;

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        onb_node_cell #(.LEVELS(LEVELS), .LVL(g)) u_cell (
            .i_clk      (i_clk),
            .i_en       (b_go),
            .i_seeded   (r_seeded),
            .i_last     (r_b_last),
            .i_limit    (r_limit),
            .i_part     (r_b_part),
            .i_link     (links[g]),
            .o_link     (links[g+1]),
            .o_old      (old_n[g]),
            .o_old_flag (old_flag[g]),
            .o_new      (new_n[g]),
            .o_dump_flag(dump_flag[g])
        );
        // closed nodes first, then the dumped stack with the root marked
        assign load_ent[g].flag            = old_flag[g];
        assign load_ent[g].tree_end        = 1'b0;
        assign load_ent[g].node            = old_n[g];
        assign load_ent[LEVELS+g].flag     = dump_flag[g];
        assign load_ent[LEVELS+g].tree_end = (g == 0);
        assign load_ent[LEVELS+g].node     = new_n[g];
    end

    assign ent[SLOTS] = '0;
    assign out_take   = ~r_o_valid | ~i_out_stall;
    assign shift      = ~ent[0].flag | out_take;

    for (genvar s = 0; s < SLOTS; s++) begin : g_slot
        onb_emit_cell u_slot (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (b_go),
            .i_shift     (shift),
            .i_load_entry(load_ent[s]),
            .i_next      (ent[s+1]),
            .o_entry     (ent[s])
        );
        assign ent_flag[s] = ent[s].flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_take) begin
            r_o_valid <= ent[0].flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && ent[0].flag) begin
            r_o_node <= ent[0].node;
            r_o_end  <= ent[0].tree_end;
            r_o_last <= ~|ent_flag[SLOTS-1:1];
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_node_prefix = r_o_node.key;
    assign o_node_level  = r_o_node.level;
    assign o_sum_x       = r_o_node.sx;
    assign o_sum_y       = r_o_node.sy;
    assign o_sum_z       = r_o_node.sz;
    assign o_total_mass  = r_o_node.mass;
    assign o_node_count  = r_o_node.count;
    assign o_start_index = r_o_node.start;
    assign o_tree_end    = r_o_end;
    assign o_last_of_run = r_o_last;

endmodule

[src/onb_checker.sv]
// port-level checks for the octree node builder, bound to the top level
module onb_checker import onb_pkg::*; #(
    parameter int LEVELS = 21
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [LVL_W-1:0] o_node_level,
    input logic [KEY_W-1:0] o_node_prefix,
    input logic             o_tree_end,
    input logic             o_cfg_ready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_node_prefix))
        else $error("stalled node changed");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_node_level != '0 && o_node_level <= LVL_W'(LEVELS))
        else $error("node level out of range");

    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tree_end |-> o_node_level == LVL_W'(1))
        else $error("tree end on non-root node");

    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && o_cfg_ready)
        else $error("output valid right after reset");

endmodule

bind octree_node_builder onb_checker #(.LEVELS(LEVELS)) u_onb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_node_level (o_node_level),
    .o_node_prefix(o_node_prefix),
    .o_tree_end   (o_tree_end),
    .o_cfg_ready  (o_cfg_ready)
);
